// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define PCP_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("permutation_cycle_product: assertion failed");

// Next-cycle implication, switched off while reset is held.
`define PCP_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("permutation_cycle_product: assertion failed");

`endif

// File: rtl/pcp_pkg.sv
`default_nettype none

package pcp_pkg;

  localparam int FORMULA_DEPTH = 32;
  localparam int MAX_RESULTS   = 48;

  localparam int POS_W = $clog2(FORMULA_DEPTH + 1);
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam pos_t DEPTH_POS = pos_t'(FORMULA_DEPTH);
  localparam pos_t LAST_POS  = pos_t'(FORMULA_DEPTH - 1);
  localparam cnt_t MAX_CNT   = cnt_t'(MAX_RESULTS);

  localparam logic [7:0] SYM_OPEN  = 8'd40;
  localparam logic [7:0] SYM_CLOSE = 8'd41;

  typedef struct packed {
    logic [7:0] sym;
    logic       tag;
  } entry_t;

  // Commands from the controller to the row of cells.
  typedef struct packed {
    logic   shift;
    logic   load;
    logic   mark;
    entry_t fresh;
  } chain_ctl_t;

  // Requests from the controller to the output stage.
  typedef struct packed {
    logic       emit;
    logic [7:0] sym;
    logic       flush;
    logic       ovf;
  } emit_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_OVF,
    ST_REWIND_FIND,
    ST_FIND,
    ST_OPEN,
    ST_HEAD,
    ST_NEXT,
    ST_SEARCH,
    ST_REWIND_SEARCH,
    ST_CLOSE,
    ST_FLUSH
  } state_t;

endpackage

`default_nettype wire

// File: rtl/permutation_cycle_product.sv
// While loading, a symbol is taken whenever in_valid is high; the symbol marked last starts the product.
// The product walks a ring of FORMULA_DEPTH cells past one head cell, one entry per
// cycle while stalls from out_ready do not hold it; each scan or rewind passes the
// ring at most once.
// Results leave one per cycle at most; no new symbol is taken until the run ends.
// Synchronous active-high reset clears control state; the ring needs no clearing pass.
`default_nettype none

module permutation_cycle_product (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] symbol,
  input  wire logic       last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_symbol,
  output logic            out_last,
  output logic            overflow
);

  pcp_pkg::chain_ctl_t ctl;
  pcp_pkg::emit_t      em;
  pcp_pkg::entry_t     head;
  logic                out_free;

  pcp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .symbol   (symbol),
    .last     (last),
    .head     (head),
    .out_free (out_free),
    .ctl      (ctl),
    .em       (em)
  );

  pcp_chain u_chain (
    .clk  (clk),
    .ctl  (ctl),
    .head (head)
  );

  pcp_out u_out (
    .clk        (clk),
    .rst        (rst),
    .em         (em),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_symbol (out_symbol),
    .out_last   (out_last),
    .overflow   (overflow)
  );

endmodule

`default_nettype wire

// File: rtl/pcp_cell.sv
`default_nettype none

module pcp_cell (
  input  wire logic            clk,
  input  wire logic            shift,
  input  wire logic            mark,
  input  wire pcp_pkg::entry_t d,
  output pcp_pkg::entry_t      q
);

  // The tag of the word passing in may be set on its way.
  always_ff @(posedge clk) begin
    if (shift) begin
      q.sym <= d.sym;
      q.tag <= d.tag | mark;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pcp_chain.sv
`default_nettype none

module pcp_chain (
  input  wire logic                clk,
  input  wire pcp_pkg::chain_ctl_t ctl,
  output pcp_pkg::entry_t          head
);

  pcp_pkg::entry_t q [pcp_pkg::FORMULA_DEPTH];
  pcp_pkg::entry_t d [pcp_pkg::FORMULA_DEPTH];
  pcp_pkg::entry_t feed;

  // While loading, new words enter at the tail; otherwise the ring closes on itself.
  assign feed = ctl.load ? ctl.fresh : q[0];
  assign head = q[0];

  for (genvar j = 0; j < pcp_pkg::FORMULA_DEPTH; j++) begin : g_cell
    if (j == pcp_pkg::FORMULA_DEPTH - 1) begin : g_tail
      assign d[j] = feed;
      pcp_cell u_cell (
        .clk   (clk),
        .shift (ctl.shift),
        .mark  (ctl.mark & ~ctl.load),
        .d     (d[j]),
        .q     (q[j])
      );
    end else begin : g_body
      assign d[j] = q[j+1];
      pcp_cell u_cell (
        .clk   (clk),
        .shift (ctl.shift),
        .mark  (1'b0),
        .d     (d[j]),
        .q     (q[j])
      );
    end
  end

endmodule

`default_nettype wire

// File: rtl/pcp_ctrl.sv
`default_nettype none

module pcp_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      symbol,
  input  wire logic            last,
  input  wire pcp_pkg::entry_t head,
  input  wire logic            out_free,
  output pcp_pkg::chain_ctl_t  ctl,
  output pcp_pkg::emit_t       em
);

  pcp_pkg::state_t state, state_next;
  pcp_pkg::pos_t   pos, pos_next;
  pcp_pkg::pos_t   fill;
  logic [7:0]      start;
  logic [7:0]      cur;
  logic            wrapped;
  logic [7:0]      cycle_head;
  logic            expect_head;
  logic            overflowed;

  logic accept;
  logic has_room;
  logic in_range;
  logic head_hit;
  logic closes;
  logic rewinding;
  logic clear;

  assign accept    = in_valid && in_ready;
  assign has_room  = fill < pcp_pkg::DEPTH_POS;
  assign in_range  = pos < fill;
  assign head_hit  = !head.tag && (head.sym == cur);
  assign closes    = (cur == start) || wrapped;
  assign rewinding = (state == pcp_pkg::ST_REWIND_FIND) ||
                     (state == pcp_pkg::ST_REWIND_SEARCH);
  assign clear     = out_free &&
                     ((state == pcp_pkg::ST_FLUSH) || (state == pcp_pkg::ST_OVF));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pcp_pkg::ST_LOAD: begin
        if (accept && last) begin
          if (overflowed || !has_room) begin
            state_next = pcp_pkg::ST_OVF;
          end else begin
            state_next = pcp_pkg::ST_REWIND_FIND;
          end
        end
      end
      pcp_pkg::ST_OVF: begin
        if (out_free) state_next = pcp_pkg::ST_LOAD;
      end
      pcp_pkg::ST_REWIND_FIND: begin
        if (out_free && pos == '0) state_next = pcp_pkg::ST_FIND;
      end
      pcp_pkg::ST_FIND: begin
        if (out_free) begin
          if (!in_range) begin
            state_next = pcp_pkg::ST_FLUSH;
          end else if (!head.tag) begin
            state_next = pcp_pkg::ST_OPEN;
          end
        end
      end
      pcp_pkg::ST_OPEN: begin
        if (out_free) state_next = pcp_pkg::ST_HEAD;
      end
      pcp_pkg::ST_HEAD: begin
        if (out_free) state_next = pcp_pkg::ST_NEXT;
      end
      pcp_pkg::ST_NEXT: begin
        if (out_free) state_next = pcp_pkg::ST_SEARCH;
      end
      pcp_pkg::ST_SEARCH: begin
        if (out_free) begin
          if (in_range) begin
            if (head_hit) state_next = pcp_pkg::ST_NEXT;
          end else if (closes) begin
            state_next = pcp_pkg::ST_CLOSE;
          end else begin
            state_next = pcp_pkg::ST_REWIND_SEARCH;
          end
        end
      end
      pcp_pkg::ST_REWIND_SEARCH: begin
        if (out_free && pos == '0) state_next = pcp_pkg::ST_SEARCH;
      end
      pcp_pkg::ST_CLOSE: begin
        if (out_free) state_next = pcp_pkg::ST_REWIND_FIND;
      end
      pcp_pkg::ST_FLUSH: begin
        if (out_free) state_next = pcp_pkg::ST_LOAD;
      end
      default: state_next = pcp_pkg::ST_LOAD;
    endcase
  end

  // Outputs to the ring and to the output stage.
  always_comb begin
    in_ready = 1'b0;
    ctl      = '0;
    em       = '0;
    unique case (state) inside
      pcp_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid && has_room) begin
          ctl.shift = 1'b1;
          ctl.load  = 1'b1;
          if (symbol == pcp_pkg::SYM_OPEN) begin
            ctl.fresh = '{sym: pcp_pkg::SYM_OPEN, tag: 1'b1};
          end else if (symbol == pcp_pkg::SYM_CLOSE) begin
            // A closing parenthesis is kept as a tagged copy of the cycle's first letter.
            ctl.fresh = '{sym: cycle_head, tag: 1'b1};
          end else begin
            ctl.fresh = '{sym: symbol, tag: 1'b0};
          end
        end
      end
      pcp_pkg::ST_OVF: begin
        em.ovf = out_free;
      end
      pcp_pkg::ST_REWIND_FIND, pcp_pkg::ST_REWIND_SEARCH: begin
        ctl.shift = out_free && (pos != '0) && (pos != pcp_pkg::DEPTH_POS);
      end
      pcp_pkg::ST_FIND: begin
        ctl.shift = out_free && in_range;
        ctl.mark  = !head.tag;
      end
      pcp_pkg::ST_OPEN: begin
        em.emit = out_free;
        em.sym  = pcp_pkg::SYM_OPEN;
      end
      pcp_pkg::ST_HEAD: begin
        em.emit = out_free;
        em.sym  = start;
      end
      pcp_pkg::ST_NEXT: begin
        ctl.shift = out_free && in_range;
      end
      pcp_pkg::ST_SEARCH: begin
        if (in_range) begin
          ctl.shift = out_free;
          ctl.mark  = head_hit;
        end else begin
          // No untagged match to the right: unless the cycle closes, name the letter and rescan from the left.
          em.emit = out_free && !closes;
          em.sym  = cur;
        end
      end
      pcp_pkg::ST_CLOSE: begin
        em.emit = out_free;
        em.sym  = pcp_pkg::SYM_CLOSE;
      end
      pcp_pkg::ST_FLUSH: begin
        em.flush = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // The position of the word in the head cell follows every rotation of the ring.
  always_comb begin
    pos_next = pos;
    if (clear) begin
      pos_next = '0;
    end else if (rewinding && out_free && pos == pcp_pkg::DEPTH_POS) begin
      pos_next = '0;
    end else if (ctl.shift) begin
      if (rewinding && pos == pcp_pkg::LAST_POS) begin
        pos_next = '0;
      end else begin
        pos_next = pos + pcp_pkg::pos_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pcp_pkg::ST_LOAD;
      pos         <= '0;
      fill        <= '0;
      cycle_head  <= '0;
      expect_head <= 1'b0;
      overflowed  <= 1'b0;
      wrapped     <= 1'b0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      if (clear) begin
        fill        <= '0;
        cycle_head  <= '0;
        expect_head <= 1'b0;
        overflowed  <= 1'b0;
      end else if (accept) begin
        if (!has_room) begin
          overflowed <= 1'b1;
        end else begin
          fill <= fill + pcp_pkg::pos_t'(1);
          if (symbol == pcp_pkg::SYM_OPEN) begin
            expect_head <= 1'b1;
          end else if (symbol != pcp_pkg::SYM_CLOSE && expect_head) begin
            cycle_head  <= symbol;
            expect_head <= 1'b0;
          end
        end
      end
      if (out_free && state == pcp_pkg::ST_NEXT) begin
        wrapped <= 1'b0;
      end else if (em.emit && state == pcp_pkg::ST_SEARCH) begin
        wrapped <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && state == pcp_pkg::ST_FIND && in_range && !head.tag) begin
      start <= head.sym;
    end
    if (out_free && state == pcp_pkg::ST_NEXT) begin
      cur <= in_range ? head.sym : start;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pcp_out.sv
`default_nettype none

module pcp_out (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire pcp_pkg::emit_t em,
  output logic                out_free,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_symbol,
  output logic                out_last,
  output logic                overflow
);

  logic          hold_valid;
  logic [7:0]    hold_sym;
  pcp_pkg::cnt_t count;

  logic keep;
  logic push;
  logic flush;
  logic out_load;

  // One character is held back so that the final one can be marked when the run ends.
  assign out_free = !out_valid || out_ready;
  assign keep     = em.emit && (count < pcp_pkg::MAX_CNT);
  assign push     = keep && hold_valid;
  assign flush    = em.flush && hold_valid;
  assign out_load = push || flush || em.ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
      count      <= '0;
    end else begin
      if (out_free) out_valid <= out_load;
      if (em.flush) begin
        hold_valid <= 1'b0;
        count      <= '0;
      end else if (keep) begin
        hold_valid <= 1'b1;
        count      <= count + pcp_pkg::cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (keep) hold_sym <= em.sym;
    if (out_free && out_load) begin
      if (em.ovf) begin
        out_symbol <= '0;
        out_last   <= 1'b1;
        overflow   <= 1'b1;
      end else begin
        out_symbol <= hold_sym;
        out_last   <= flush;
        overflow   <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/pcp_checker.sv
`default_nettype none
`include "assert_macros.svh"

module pcp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       last,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_symbol,
  input wire logic       out_last,
  input wire logic       overflow
);

  // The overflow word stands alone and carries no character.
  `PCP_ASSERT_NOW(a_ovf_alone, clk, rst, out_valid && overflow, out_last && out_symbol == 8'd0)

  // While more words of a run are to come, no new formula is taken.
  `PCP_ASSERT_NOW(a_busy_mid_run, clk, rst, out_valid && !out_last, !in_ready)

  // The final symbol of a formula ends loading at once: the product starts, or the overflow is reported.
  `PCP_ASSERT_NEXT(a_last_starts, clk, rst, in_valid && in_ready && last, !in_ready)

  // A word that is not taken stays put.
  `PCP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
                   out_valid && $stable(out_symbol) && $stable(out_last))

endmodule

bind permutation_cycle_product pcp_checker u_checker (.*);

`default_nettype wire
